/* sv/ldws_pkg.sv */
// Shared constants and types of the link delay window statistics block.
// No dependencies; the top level and the checker refer to it by scoped names.

package ldws_pkg;

	// Default sizes
	localparam int WINDOW_DEF  = 5;
	localparam int DEVICES_DEF = 16;

	// Field widths
	localparam int DEV_W   = 4;
	localparam int DELAY_W = 16;
	localparam int STAT_W  = 24;
	localparam int CNT_W   = 3;
	localparam int FRAC_W  = 8;

	// Stream widths
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 64;
	localparam int M_TUSER_W = 1;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POS,
		ST_SCAN,
		ST_CALC,
		ST_MDIV,
		ST_VLOAD,
		ST_VDIV,
		ST_ROOT,
		ST_OUT
	} state_t;

endpackage

/* sv/ldws_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered data.
// Depends on nothing.

module ldws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/link_delay_window_statistics.sv */
// Top level of the link delay window statistics block.
// Depends on ldws_pkg and instantiates ldws_ram for the window positions and the probe ring.
//
// Each input item is one probe outcome (a round-trip delay or a lost mark) of one link partner.
// The block stores it in the partner's ring of WINDOW entries; every WINDOW-th probe of a
// partner closes its window and produces one result item with the mean delay and the sample
// standard deviation (divisor n-1) of the received delays, both unsigned Q.8 ms truncated, plus
// the received and lost counts. All lost gives none_received = 1 with zero statistics; a single
// received sample gives a zero deviation. Probes for a partner at or above DEVICES are taken and
// dropped. One item is worked on at a time. A probe that does not close a window goes through
// the position read and the ring write. A closing probe then walks the ring, forms the products,
// runs the mean divide, forms the spread, runs the variance divide and the square root, and hands
// off the result; the divider is radix-4 and the square root works on bit pairs. The result sits
// in an output register, so the next probe is taken while it waits. Window positions start at
// zero after reset through per-partner valid flags; no clearing pass is needed.

module link_delay_window_statistics #(
	parameter int WINDOW  = ldws_pkg::WINDOW_DEF,
	parameter int DEVICES = ldws_pkg::DEVICES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ldws_pkg::S_TDATA_W-1:0] s_tdata,   // device[3:0], rtt_ms[19:4], zero pad
	input  logic [ldws_pkg::S_TUSER_W-1:0] s_tuser,   // lost[0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ldws_pkg::M_TDATA_W-1:0] m_tdata,   // device_out[3:0], mean_delay_q8[27:4],
	                                                  // std_dev_q8[51:28], received_count[54:52],
	                                                  // lost_count[57:55], zero pad
	output logic [ldws_pkg::M_TUSER_W-1:0] m_tuser    // none_received[0]
);

	localparam int DEV_W   = ldws_pkg::DEV_W;
	localparam int DELAY_W = ldws_pkg::DELAY_W;
	localparam int STAT_W  = ldws_pkg::STAT_W;
	localparam int CNT_W   = ldws_pkg::CNT_W;
	localparam int FRAC_W  = ldws_pkg::FRAC_W;

	localparam int PW      = $clog2(WINDOW);
	localparam int NW      = $clog2(WINDOW + 1);
	localparam int DEV_AW  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam int RING_D  = DEVICES * WINDOW;
	localparam int RING_AW = $clog2(RING_D);
	localparam int RING_W  = DELAY_W + 1;
	localparam int S1W     = DELAY_W + NW;
	localparam int S2W     = 2 * DELAY_W + NW;
	localparam int SPW     = S2W + NW;
	localparam int DW      = 2 * NW;
	localparam int QW0     = SPW + 2 * FRAC_W;
	localparam int QW      = QW0 + (QW0 % 2);
	localparam int RTW     = QW / 2;
	localparam int MNW     = S1W + FRAC_W;
	localparam int MSTEPS  = (MNW + 1) / 2;
	localparam int MNW2    = 2 * MSTEPS;
	localparam int VSTEPS  = QW / 2;
	localparam int STEPW   = $clog2(QW);

	ldws_pkg::state_t state_q, state_d;

	// Sequencer strobes
	logic s_acc, dev_ok, pos_re, ring_re, out_free, out_load;

	// Item registers
	logic [DEV_W-1:0]   dev_q;
	logic [DELAY_W-1:0] rtt_q;
	logic               lost_q;
	logic [RING_AW-1:0] base_q;
	logic [DEV_AW-1:0]  dev_idx;

	// Window position store
	logic [DEVICES-1:0] pos_vld_q;
	logic [PW-1:0]      pos_rdata, pos_cur, pos_wdata;
	logic [PW:0]        pos_inc;
	logic               pos_last;

	// Ring store
	logic [RING_AW-1:0] ring_waddr, ring_raddr;
	logic [RING_W-1:0]  ring_wdata, ring_rdata;
	logic               ring_we;

	// Walk and sums
	logic [NW-1:0]        scan_idx_q;
	logic                 rd_vld_s1;
	logic [NW-1:0]        n_q, nl_q;
	logic [S1W-1:0]       s1_q;
	logic [S2W-1:0]       s2_q;
	logic [2*DELAY_W-1:0] sq;
	logic [SPW-1:0]       s1sq_q, ns2_q, spread;

	// Divider and root
	logic [STEPW-1:0] step_q;
	logic [QW-1:0]    dq_q, div_q_nx;
	logic [DW-1:0]    dr_q, dd_q, div_r_nx, r1;
	logic             b1, b2;
	logic [QW-1:0]    rad_q;
	logic [RTW-1:0]   root_q, root_nx;
	logic [RTW+1:0]   srem_q, srem_nx;
	logic [RTW+3:0]   sq_t, sq_trial;

	// Results
	logic [STAT_W-1:0] mean_q, sd_q;
	logic              m_tvalid_q;
	logic [DEV_W-1:0]  out_dev_q;
	logic [STAT_W-1:0] out_mean_q, out_sd_q;
	logic [CNT_W-1:0]  out_rc_q, out_lc_q;
	logic              out_none_q;

	// One restoring division step: returns {quotient bit, new remainder}
	function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic b,
			input logic [DW-1:0] d);
		logic [DW:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			return {1'b1, DW'(t - {1'b0, d})};
		end
		return {1'b0, t[DW-1:0]};
	endfunction

	assign s_acc    = s_tvalid && s_tready;
	assign dev_ok   = 32'(s_tdata[DEV_W-1:0]) < 32'(DEVICES);
	assign out_free = !m_tvalid_q || m_tready;
	assign dev_idx  = DEV_AW'(dev_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ldws_pkg::ST_IDLE: begin
				if (s_acc && dev_ok) state_d = ldws_pkg::ST_POS;
			end
			ldws_pkg::ST_POS: begin
				state_d = pos_last ? ldws_pkg::ST_SCAN : ldws_pkg::ST_IDLE;
			end
			ldws_pkg::ST_SCAN: begin
				if (scan_idx_q == NW'(WINDOW) && rd_vld_s1) state_d = ldws_pkg::ST_CALC;
			end
			ldws_pkg::ST_CALC: begin
				state_d = (n_q == '0) ? ldws_pkg::ST_OUT : ldws_pkg::ST_MDIV;
			end
			ldws_pkg::ST_MDIV: begin
				if (step_q == STEPW'(MSTEPS - 1)) begin
					state_d = (n_q < NW'(2)) ? ldws_pkg::ST_OUT : ldws_pkg::ST_VLOAD;
				end
			end
			ldws_pkg::ST_VLOAD: begin
				state_d = ldws_pkg::ST_VDIV;
			end
			ldws_pkg::ST_VDIV: begin
				if (step_q == STEPW'(VSTEPS - 1)) state_d = ldws_pkg::ST_ROOT;
			end
			ldws_pkg::ST_ROOT: begin
				if (step_q == STEPW'(RTW - 1)) state_d = ldws_pkg::ST_OUT;
			end
			ldws_pkg::ST_OUT: begin
				if (out_free) state_d = ldws_pkg::ST_IDLE;
			end
			default: state_d = ldws_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		pos_re   = 1'b0;
		ring_we  = 1'b0;
		ring_re  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ldws_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				pos_re   = s_tvalid;
			end
			ldws_pkg::ST_POS:  ring_we  = 1'b1;
			ldws_pkg::ST_SCAN: ring_re  = scan_idx_q < NW'(WINDOW);
			ldws_pkg::ST_OUT:  out_load = out_free;
			default: ;
		endcase
	end

	// Window position of the current partner, then advance and wrap
	always_comb begin
		pos_cur = pos_vld_q[dev_idx] ? pos_rdata : '0;
		if ((PW + 1)'(pos_cur) >= (PW + 1)'(WINDOW)) pos_cur = '0;
		pos_inc   = (PW + 1)'(pos_cur) + (PW + 1)'(1);
		pos_last  = pos_inc == (PW + 1)'(WINDOW);
		pos_wdata = pos_last ? '0 : PW'(pos_inc);
	end

	assign ring_waddr = base_q + RING_AW'(pos_cur);
	assign ring_wdata = {lost_q, lost_q ? DELAY_W'(0) : rtt_q};
	assign ring_raddr = base_q + RING_AW'(scan_idx_q);

	ldws_ram #(
		.WIDTH(PW),
		.DEPTH(DEVICES)
	) u_pos_ram (
		.clk  (clk),
		.we   (ring_we),
		.waddr(dev_idx),
		.wdata(pos_wdata),
		.re   (pos_re),
		.raddr(DEV_AW'(s_tdata[DEV_W-1:0])),
		.rdata(pos_rdata)
	);

	ldws_ram #(
		.WIDTH(RING_W),
		.DEPTH(RING_D)
	) u_ring_ram (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(ring_wdata),
		.re   (ring_re),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	// Square of the delay coming back from the ring
	assign sq = ring_rdata[DELAY_W-1:0] * ring_rdata[DELAY_W-1:0];

	// Two division steps per cycle
	always_comb begin
		{b1, r1}       = div_step(dr_q, dq_q[QW-1], dd_q);
		{b2, div_r_nx} = div_step(r1, dq_q[QW-2], dd_q);
		div_q_nx       = {dq_q[QW-3:0], b1, b2};
	end

	// One root bit per cycle
	always_comb begin
		sq_t     = {srem_q, rad_q[QW-1:QW-2]};
		sq_trial = (RTW + 4)'({root_q, 2'b01});
		if (sq_t >= sq_trial) begin
			srem_nx = (RTW + 2)'(sq_t - sq_trial);
			root_nx = {root_q[RTW-2:0], 1'b1};
		end else begin
			srem_nx = (RTW + 2)'(sq_t);
			root_nx = {root_q[RTW-2:0], 1'b0};
		end
	end

	assign spread = ns2_q - s1sq_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ldws_pkg::ST_IDLE;
			pos_vld_q  <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_q != state_d) ? '0 : step_q + STEPW'(1);
			if (ring_we) pos_vld_q[dev_idx] <= 1'b1;
			if (state_q == ldws_pkg::ST_POS) begin
				scan_idx_q <= '0;
				rd_vld_s1  <= 1'b0;
			end else begin
				rd_vld_s1 <= ring_re;
				if (ring_re) scan_idx_q <= scan_idx_q + NW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// Hold the accepted item
		if (state_q == ldws_pkg::ST_IDLE && s_acc) begin
			dev_q  <= s_tdata[DEV_W-1:0];
			rtt_q  <= s_tdata[DEV_W +: DELAY_W];
			lost_q <= s_tuser[0];
			base_q <= RING_AW'(RING_AW'(s_tdata[DEV_W-1:0]) * RING_AW'(WINDOW));
		end
		case (state_q)
			ldws_pkg::ST_POS: begin
				n_q  <= '0;
				nl_q <= '0;
				s1_q <= '0;
				s2_q <= '0;
			end
			ldws_pkg::ST_SCAN: begin
				// Sum the window as it comes back from the ring
				if (rd_vld_s1) begin
					if (ring_rdata[DELAY_W]) begin
						nl_q <= nl_q + NW'(1);
					end else begin
						n_q  <= n_q + NW'(1);
						s1_q <= s1_q + S1W'(ring_rdata[DELAY_W-1:0]);
						s2_q <= s2_q + S2W'(sq);
					end
				end
			end
			ldws_pkg::ST_CALC: begin
				s1sq_q <= SPW'(SPW'(s1_q) * SPW'(s1_q));
				ns2_q  <= SPW'(SPW'(n_q) * SPW'(s2_q));
				mean_q <= '0;
				sd_q   <= '0;
				dq_q   <= QW'({MNW2'({s1_q, {FRAC_W{1'b0}}}), {(QW - MNW2){1'b0}}});
				dr_q   <= '0;
				dd_q   <= DW'(n_q);
			end
			ldws_pkg::ST_MDIV: begin
				dq_q <= div_q_nx;
				dr_q <= div_r_nx;
				if (step_q == STEPW'(MSTEPS - 1)) mean_q <= div_q_nx[STAT_W-1:0];
			end
			ldws_pkg::ST_VLOAD: begin
				dq_q <= QW'({spread, {(2 * FRAC_W){1'b0}}});
				dr_q <= '0;
				dd_q <= DW'(DW'(n_q) * DW'(n_q - NW'(1)));
			end
			ldws_pkg::ST_VDIV: begin
				dq_q <= div_q_nx;
				dr_q <= div_r_nx;
				if (step_q == STEPW'(VSTEPS - 1)) begin
					rad_q  <= div_q_nx;
					root_q <= '0;
					srem_q <= '0;
				end
			end
			ldws_pkg::ST_ROOT: begin
				rad_q  <= {rad_q[QW-3:0], 2'b00};
				root_q <= root_nx;
				srem_q <= srem_nx;
				if (step_q == STEPW'(RTW - 1)) sd_q <= root_nx[STAT_W-1:0];
			end
			default: ;
		endcase
		// Load the output register
		if (out_load) begin
			out_dev_q  <= dev_q;
			out_mean_q <= mean_q;
			out_sd_q   <= sd_q;
			out_rc_q   <= CNT_W'(n_q);
			out_lc_q   <= CNT_W'(nl_q);
			out_none_q <= n_q == '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = ldws_pkg::M_TDATA_W'({out_lc_q, out_rc_q, out_sd_q, out_mean_q, out_dev_q});
	assign m_tuser  = out_none_q;

endmodule

/* sv/ldws_chk.sv */
// Port-level checker of the link delay window statistics block, bound to its top level.
// Depends on ldws_pkg and on the top level's port names.

module ldws_chk #(
	parameter int WINDOW  = ldws_pkg::WINDOW_DEF,
	parameter int DEVICES = ldws_pkg::DEVICES_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [ldws_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [ldws_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ldws_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [ldws_pkg::M_TUSER_W-1:0] m_tuser
);

	// A stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	// Received and lost counts cover the whole window
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 3'(m_tdata[54:52] + m_tdata[57:55]) == 3'(WINDOW))
		else $error("counts do not add up to the window");

	// All lost: zero statistics and no received sample
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[27:4] == '0 && m_tdata[51:28] == '0
			&& m_tdata[54:52] == '0)
		else $error("all-lost result carries statistics");

	// A single received sample has no spread
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (WINDOW < 8) && m_tdata[54:52] == 3'd1 |-> m_tdata[51:28] == '0)
		else $error("deviation of a single sample is not zero");

	// A probe for a known partner is worked on before the next one is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && 32'(s_tdata[3:0]) < 32'(DEVICES) |=> !s_tready)
		else $error("input taken while an item is in work");

endmodule

bind link_delay_window_statistics ldws_chk #(
	.WINDOW (WINDOW),
	.DEVICES(DEVICES)
) u_ldws_chk (.*);
